// ===== src/hsv_pkg.sv =====
// Package for the HSV to RGB converter: field widths, pixel structs,
// sextant codes and the divide-by-full-scale helper. No dependencies.
package hsv_pkg;

    localparam int CHANNEL_BITS = 8;
    localparam int HUE_W        = 13;
    localparam int REM_W        = 10;
    localparam int HUE_SEXTANT  = 960;
    localparam int HUE_FULL     = 6 * HUE_SEXTANT;

    localparam logic [CHANNEL_BITS-1:0] CHAN_MAX = {CHANNEL_BITS{1'b1}};
    localparam logic [2*CHANNEL_BITS-1:0] HALF_M =
        (2*CHANNEL_BITS)'((2**CHANNEL_BITS - 1) / 2);

    // q and t share the denominator M * 960
    localparam int DEN_W = CHANNEL_BITS + REM_W;
    localparam int unsigned DEN_I = (2**CHANNEL_BITS - 1) * HUE_SEXTANT;
    localparam logic [DEN_W-1:0] DEN = DEN_W'(DEN_I);
    localparam int X_W = 2 * CHANNEL_BITS + REM_W;
    localparam logic [X_W-1:0] HALF_DEN = X_W'(DEN_I / 2);

    // numerator after >>6 is divided by 15 with a floor reciprocal
    localparam int Y_W     = X_W - 6;
    localparam int RECIP_W = Y_W - 3;
    localparam int A_W     = Y_W - 3;
    localparam longint unsigned RECIP_L = (64'd1 << Y_W) / 15;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);
    localparam int PROD_W  = Y_W + RECIP_W;

    localparam int SUM_W = 2 * CHANNEL_BITS + 1;

    typedef enum logic [2:0] {
        SEXT_RY = 3'd0,
        SEXT_YG = 3'd1,
        SEXT_GC = 3'd2,
        SEXT_CB = 3'd3,
        SEXT_BM = 3'd4,
        SEXT_MR = 3'd5
    } t_sextant;

    typedef struct packed {
        logic [HUE_W-1:0]        hue_angle;
        logic [CHANNEL_BITS-1:0] saturation;
        logic [CHANNEL_BITS-1:0] brightness;
    } t_hsv;

    typedef struct packed {
        logic [CHANNEL_BITS-1:0] red;
        logic [CHANNEL_BITS-1:0] green;
        logic [CHANNEL_BITS-1:0] blue;
    } t_rgb;

    // floor(a / (2^N - 1)), exact for a below (2^N - 1) * 2^N
    function automatic logic [CHANNEL_BITS-1:0] div_by_m(
        input logic [2*CHANNEL_BITS-1:0] a
    );
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(a) + SUM_W'(a >> CHANNEL_BITS) + SUM_W'(1);
        return sum[2*CHANNEL_BITS-1:CHANNEL_BITS];
    endfunction

endpackage

// ===== src/hsv_den_div.sv =====
// Three-stage pipelined divider by M * 960 (floor) for the q and t products.
// Depends on hsv_pkg.
module hsv_den_div
    import hsv_pkg::*;
(
    input  logic                    i_clk,
    input  logic [X_W-1:0]          i_num,
    output logic [CHANNEL_BITS-1:0] o_quo
);

    logic [Y_W-1:0]          r_y;
    logic [PROD_W-1:0]       r_prod;
    logic [A_W-1:0]          r_a;
    logic [CHANNEL_BITS-1:0] r_quo;

    logic [Y_W-1:0] y;
    logic [A_W-1:0] q0;
    logic [Y_W-1:0] resid;
    logic [A_W-1:0] n_a;

    // /64 is a shift; /15 by reciprocal, low by at most one
    assign y = i_num[X_W-1:6];

    always_comb begin
        q0    = r_prod[PROD_W-1:Y_W];
        resid = r_y - ((Y_W'(q0) << 4) - Y_W'(q0));
        n_a   = (resid >= Y_W'(15)) ? q0 + A_W'(1) : q0;
    end

    always_ff @(posedge i_clk) begin
        r_y    <= y;
        r_prod <= PROD_W'(y) * PROD_W'(RECIP);
        r_a    <= n_a;
        r_quo  <= div_by_m(r_a[2*CHANNEL_BITS-1:0]);
    end

    assign o_quo = r_quo;

endmodule

// ===== src/hsv_to_rgb_converter.sv =====
// HSV to RGB pixel converter, top level.
// Depends on hsv_pkg and hsv_den_div.
//
// Usage:
//   Input channel: drive i_hsv and raise start; the item is taken at a
//   rising edge where start is high and busy is low. busy is always low:
//   the pipeline takes one pixel every clock, back to back.
//   Output channel: o_valid marks a result on o_rgb for exactly one cycle.
//   The receiver cannot stall, so nothing ever backs up into the pipe.
//   The result shows on o_rgb in the cycle that begins when the 7th
//   register stage is loaded, and is taken at the edge that ends that
//   cycle. Throughput: 1 pixel per clock, set by the fully pipelined
//   datapath (one product layer per stage, reciprocal division spread
//   over three stages).
//   Stages: 1 hue fold and sextant split, 2 s*f products and p numerator,
//   3 v*(den - s*f) numerators and p divide, 4-6 divide by M*960 (two
//   instances, q and t), 7 channel routing into the output register.
//   Reset (i_rst_n low, synchronous) clears all valid bits; payload
//   registers are not reset. The block holds no state between pixels.
//   Zero saturation yields grey: all channels equal brightness.
module hsv_to_rgb_converter
    import hsv_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_hsv i_hsv,
    output logic o_valid,
    output t_rgb o_rgb
);

    localparam int DIV_LAT = 3;
    localparam int PRE_LAT = 3;
    localparam int VLD_N   = PRE_LAT + DIV_LAT;

    typedef struct packed {
        t_sextant                sext;
        logic [CHANNEL_BITS-1:0] val;
        logic [CHANNEL_BITS-1:0] p;
        logic                    grey;
    } t_side;

    localparam logic [HUE_W-1:0] H1 = HUE_W'(1 * HUE_SEXTANT);
    localparam logic [HUE_W-1:0] H2 = HUE_W'(2 * HUE_SEXTANT);
    localparam logic [HUE_W-1:0] H3 = HUE_W'(3 * HUE_SEXTANT);
    localparam logic [HUE_W-1:0] H4 = HUE_W'(4 * HUE_SEXTANT);
    localparam logic [HUE_W-1:0] H5 = HUE_W'(5 * HUE_SEXTANT);
    localparam logic [HUE_W-1:0] HF = HUE_W'(HUE_FULL);

    // valid bits for stages 1..6; output strobe separately
    logic [VLD_N-1:0] r_vld;
    logic             r_valid;

    // stage 1
    t_sextant                r_s1_sext;
    logic [REM_W-1:0]        r_s1_rem;
    logic [CHANNEL_BITS-1:0] r_s1_sat;
    logic [CHANNEL_BITS-1:0] r_s1_val;
    // stage 2
    t_sextant                r_s2_sext;
    logic [DEN_W-1:0]        r_s2_srem;
    logic [DEN_W-1:0]        r_s2_srt;
    logic [2*CHANNEL_BITS-1:0] r_s2_pp;
    logic [CHANNEL_BITS-1:0] r_s2_val;
    logic                    r_s2_grey;
    // stage 3
    logic [X_W-1:0]          r_s3_xq;
    logic [X_W-1:0]          r_s3_xt;
    t_side                   r_s3_side;
    // stages 4..6 sideband
    t_side                   r_side [DIV_LAT];
    // output
    t_rgb                    r_rgb;

    logic [HUE_W-1:0]        h;
    t_sextant                n_s1_sext;
    logic [HUE_W-1:0]        base;
    logic [CHANNEL_BITS-1:0] q_quo;
    logic [CHANNEL_BITS-1:0] t_quo;
    t_rgb                    n_rgb;
    t_side                   sd;

    assign busy = 1'b0;

    // stage 1: fold hue into the circle, pick sextant and remainder
    always_comb begin
        h = (i_hsv.hue_angle >= HF) ? '0 : i_hsv.hue_angle;
        if (h < H1) begin
            n_s1_sext = SEXT_RY;
            base      = '0;
        end else if (h < H2) begin
            n_s1_sext = SEXT_YG;
            base      = H1;
        end else if (h < H3) begin
            n_s1_sext = SEXT_GC;
            base      = H2;
        end else if (h < H4) begin
            n_s1_sext = SEXT_CB;
            base      = H3;
        end else if (h < H5) begin
            n_s1_sext = SEXT_BM;
            base      = H4;
        end else begin
            n_s1_sext = SEXT_MR;
            base      = H5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_vld   <= {r_vld[VLD_N-2:0], start & ~busy};
            r_valid <= r_vld[VLD_N-1];
        end
    end

    always_ff @(posedge i_clk) begin
        // stage 1
        r_s1_sext <= n_s1_sext;
        r_s1_rem  <= REM_W'(h - base);
        r_s1_sat  <= i_hsv.saturation;
        r_s1_val  <= i_hsv.brightness;
        // stage 2: s*f, s*(1-f) scaled by 960, and v*(1-s) scaled by M
        r_s2_sext <= r_s1_sext;
        r_s2_srem <= DEN_W'(r_s1_sat) * DEN_W'(r_s1_rem);
        r_s2_srt  <= DEN_W'(r_s1_sat) * DEN_W'(REM_W'(HUE_SEXTANT) - r_s1_rem);
        r_s2_pp   <= (2*CHANNEL_BITS)'(r_s1_val) * (2*CHANNEL_BITS)'(CHAN_MAX - r_s1_sat);
        r_s2_val  <= r_s1_val;
        r_s2_grey <= (r_s1_sat == '0);
        // stage 3: rounded numerators, p finishes here
        r_s3_xq        <= X_W'(r_s2_val) * X_W'(DEN - r_s2_srem) + HALF_DEN;
        r_s3_xt        <= X_W'(r_s2_val) * X_W'(DEN - r_s2_srt) + HALF_DEN;
        r_s3_side.sext <= r_s2_sext;
        r_s3_side.val  <= r_s2_val;
        r_s3_side.p    <= div_by_m(r_s2_pp + HALF_M);
        r_s3_side.grey <= r_s2_grey;
        // sideband rides along with the dividers
        r_side[0] <= r_s3_side;
        for (int i = 1; i < DIV_LAT; i++) begin
            r_side[i] <= r_side[i-1];
        end
        r_rgb <= n_rgb;
    end

    hsv_den_div u_div_q (
        .i_clk (i_clk),
        .i_num (r_s3_xq),
        .o_quo (q_quo)
    );

    hsv_den_div u_div_t (
        .i_clk (i_clk),
        .i_num (r_s3_xt),
        .o_quo (t_quo)
    );

    // stage 7: route v, p, q, t by sextant, or v to all channels when grey
    always_comb begin
        sd = r_side[DIV_LAT-1];
        if (sd.grey) begin
            n_rgb = '{red: sd.val, green: sd.val, blue: sd.val};
        end else begin
            case (sd.sext)
                SEXT_RY: n_rgb = '{red: sd.val, green: t_quo,  blue: sd.p};
                SEXT_YG: n_rgb = '{red: q_quo,  green: sd.val, blue: sd.p};
                SEXT_GC: n_rgb = '{red: sd.p,   green: sd.val, blue: t_quo};
                SEXT_CB: n_rgb = '{red: sd.p,   green: q_quo,  blue: sd.val};
                SEXT_BM: n_rgb = '{red: t_quo,  green: sd.p,   blue: sd.val};
                default: n_rgb = '{red: sd.val, green: sd.p,   blue: q_quo};
            endcase
        end
    end

    assign o_valid = r_valid;
    assign o_rgb   = r_rgb;

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for hsv_to_rgb_converter: directed and random HSV pixels.
// Each result is compared with a built-in integer predictor of the conversion.
// Depends on hsv_pkg and the converter RTL.
`timescale 1ns / 1ps

module tb_top;
    import hsv_pkg::*;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    logic busy;
    t_hsv i_hsv   = '0;
    logic o_valid;
    t_rgb o_rgb;

    hsv_to_rgb_converter u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_hsv   (i_hsv),
        .o_valid (o_valid),
        .o_rgb   (o_rgb)
    );

    // 2 ns period
    always #1 i_clk = ~i_clk;

    t_hsv hsv_pending_q[$];   // items not yet offered to the block
    t_rgb rgb_expect_q[$];    // predicted pixels, oldest first
    int   drain_points[$];    // item counts at which the sender waits for an empty pipe
    int   mismatch_count = 0;
    int   items_sent     = 0;
    int   gap_left       = 0;
    int   burst_left     = 0;
    int   gap_roll;

    // Integer HSV to RGB conversion, rounded to nearest with halves up.
    function automatic t_rgb predict_rgb(t_hsv px);
        longint unsigned m, h, s, v, rem, den, p, q, t;
        t_sextant sext;
        t_rgb px_out;
        m = longint'(CHAN_MAX);
        h = px.hue_angle;
        s = px.saturation;
        v = px.brightness;
        if (s == 0) begin
            // zero saturation: grey
            px_out.red   = v[CHANNEL_BITS-1:0];
            px_out.green = v[CHANNEL_BITS-1:0];
            px_out.blue  = v[CHANNEL_BITS-1:0];
            return px_out;
        end
        // hue off the circle folds to zero
        if (h >= HUE_FULL) h = 0;
        sext = t_sextant'(3'(h / HUE_SEXTANT));
        rem  = h % HUE_SEXTANT;
        den  = m * HUE_SEXTANT;
        p = (v * (m - s) + m / 2) / m;
        q = (v * (den - s * rem) + den / 2) / den;
        t = (v * (den - s * (HUE_SEXTANT - rem)) + den / 2) / den;
        case (sext)
            SEXT_RY: px_out = {v[7:0], t[7:0], p[7:0]};
            SEXT_YG: px_out = {q[7:0], v[7:0], p[7:0]};
            SEXT_GC: px_out = {p[7:0], v[7:0], t[7:0]};
            SEXT_CB: px_out = {p[7:0], q[7:0], v[7:0]};
            SEXT_BM: px_out = {t[7:0], p[7:0], v[7:0]};
            default: px_out = {v[7:0], p[7:0], q[7:0]};
        endcase
        return px_out;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("%0t ns: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    task automatic add_px(int h, int s, int v);
        t_hsv px;
        px.hue_angle  = HUE_W'(h);
        px.saturation = CHANNEL_BITS'(s);
        px.brightness = CHANNEL_BITS'(v);
        hsv_pending_q.push_back(px);
    endtask

    // Driver: an item is taken at an edge with start high and busy low. The
    // prediction is queued at that edge, then the next item (or a gap) is set up.
    // start is assigned once per edge so back-to-back items keep it high.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                rgb_expect_q.push_back(predict_rgb(i_hsv));
            end
            if (start && busy) begin
                // offer stays up until taken
            end else if (drain_points.size() != 0 && drain_points[0] == items_sent &&
                         rgb_expect_q.size() != 0) begin
                // hold off until every outstanding pixel has come out
                start <= 1'b0;
            end else if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                start    <= 1'b0;
            end else if (hsv_pending_q.size() != 0) begin
                if (drain_points.size() != 0 && drain_points[0] == items_sent)
                    void'(drain_points.pop_front());
                i_hsv      <= hsv_pending_q.pop_front();
                start      <= 1'b1;
                items_sent <= items_sent + 1;
                // gap after this item: mostly none or short, a few long,
                // with stretches of back-to-back items
                if (burst_left > 0) begin
                    burst_left <= burst_left - 1;
                    gap_left   <= 0;
                end else begin
                    gap_roll = $urandom_range(0, 99);
                    if (gap_roll < 5)
                        burst_left <= $urandom_range(20, 60);
                    if (gap_roll < 55)
                        gap_left <= 0;
                    else if (gap_roll < 92)
                        gap_left <= $urandom_range(1, 3);
                    else
                        gap_left <= $urandom_range(8, 40);
                end
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: results cannot be held off, so each strobe is one pixel.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (rgb_expect_q.size() == 0) begin
                report_mismatch("unexpected pixel (red)", o_rgb.red, -1);
            end else begin
                t_rgb want;
                want = rgb_expect_q.pop_front();
                if (o_rgb.red !== want.red)
                    report_mismatch("red", o_rgb.red, want.red);
                if (o_rgb.green !== want.green)
                    report_mismatch("green", o_rgb.green, want.green);
                if (o_rgb.blue !== want.blue)
                    report_mismatch("blue", o_rgb.blue, want.blue);
            end
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        int roll;
        int h, s, v;
        // directed: hue edges, every sextant, grey, saturation and value extremes
        add_px(0, 255, 255);
        add_px(959, 255, 255);
        add_px(960, 255, 255);
        add_px(1919, 200, 180);
        add_px(2400, 128, 255);
        add_px(3360, 255, 100);
        add_px(4320, 77, 201);
        add_px(5280, 255, 255);
        add_px(5759, 255, 255);
        add_px(5760, 255, 255);      // off the circle, folds to zero
        add_px(8191, 1, 255);        // off the circle, minimal saturation
        add_px(7000, 128, 64);
        add_px(8191, 0, 255);        // grey, hue ignored
        add_px(1234, 0, 0);          // grey black
        add_px(0, 0, 255);           // grey white
        add_px(480, 255, 0);         // zero value
        add_px(480, 1, 1);
        add_px(3000, 255, 1);
        add_px(4000, 254, 254);
        add_px(5000, 128, 128);
        add_px(2879, 255, 255);
        add_px(2880, 255, 255);
        add_px(3839, 255, 255);
        add_px(4799, 255, 255);
        drain_points.push_back(hsv_pending_q.size());
        // random part
        for (int n = 0; n < 1000; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 80)
                h = $urandom_range(0, HUE_FULL - 1);
            else
                h = $urandom_range(HUE_FULL, 8191);
            roll = $urandom_range(0, 99);
            if (roll < 10)      s = 0;
            else if (roll < 20) s = 255;
            else                s = $urandom_range(0, 255);
            roll = $urandom_range(0, 99);
            if (roll < 5)       v = 0;
            else if (roll < 15) v = 255;
            else                v = $urandom_range(0, 255);
            add_px(h, s, v);
            if (n == 500)
                drain_points.push_back(hsv_pending_q.size());
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // sample on the falling edge, clear of the driver and monitor
        while (hsv_pending_q.size() != 0 || start) @(negedge i_clk);
        while (rgb_expect_q.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);

        if (mismatch_count == 0 && rgb_expect_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog, far above the slowest legal run.
    initial begin
        #1000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== hsv_to_rgb_converter.f =====
src/hsv_pkg.sv
src/hsv_den_div.sv
src/hsv_to_rgb_converter.sv
tb/tb_top.sv
